[hdl/bdlb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlb_pkg
// Shared sizes, register indexes, selector codes and item types of the
// batched d-choice load balancer.
// ----------------------------------------------------------------------------
package bdlb_pkg;

  localparam int MAX_BINS  = 1024;
  localparam int LOAD_BITS = 40;
  localparam int AW        = $clog2(MAX_BINS);   // bin address width
  localparam int CW        = AW + 1;             // bin count width
  localparam int TOT_BITS  = 48;
  localparam int CNT_BITS  = 20;
  localparam int DCNT_BITS = $clog2(TOT_BITS);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [CFG_IDX_BITS-1:0] REG_BINS_IN_USE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BATCH_SIZE    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SELECTOR_MODE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHOICE_COUNT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_QUANTILE_CUT  = 3'd4;

  localparam logic [2:0] MODE_D_INDEX    = 3'd0;
  localparam logic [2:0] MODE_TWO_LOAD   = 3'd1;
  localparam logic [2:0] MODE_BETA_INDEX = 3'd2;
  localparam logic [2:0] MODE_BETA_LOAD  = 3'd3;
  localparam logic [2:0] MODE_QUANTILE   = 3'd4;

  typedef struct packed {
    logic [9:0]  sample_a;
    logic [9:0]  sample_b;
    logic [9:0]  sample_c;
    logic        coin;
    logic [15:0] weight;
  } ball_t;

  typedef struct packed {
    logic [9:0]  chosen_bin;
    logic        batch_done;
    logic [39:0] max_load_out;
    logic [39:0] gap_out;
    logic        status;
  } result_t;

endpackage

[hdl/batched_d_choice_load_balancer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_d_choice_load_balancer_core
// Places weighted balls into bins by a selectable d-choice rule against the
// batch-start load vector, merges the batch buffers at batch end, heap-sorts
// the loads in descending order and reports the gap.
// ----------------------------------------------------------------------------
//
//  channel  | signals                             | handshake
//  ---------+-------------------------------------+-----------------------------
//  ball in  | start_i, busy_o, ball_i             | taken when start_i & !busy_o
//  result   | res_valid_o, res_o                  | one-cycle strobe, no stall
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i     | written when cfg_we_i
//
// Flow: after acceptance an index-rule ball passes the buffer read, buffer
// write and count states; a load-rule ball first reads both loads through the
// single memory read port and compares them; a dropped ball goes straight to
// the count state. The result strobe comes when busy_o is already low again.
// A ball that closes a batch adds the merge (a read state and a write state per
// bin, over all MAX_BINS bins), the heap sort (n/2 build sifts and n-1
// extraction sifts, each reading the children at every level it descends)
// and a restoring divide of the total weight by the bin count for the average.
// Reset: after reset a clearing pass over all MAX_BINS entries zeroes both
// memories; busy_o stays high until it ends. The receiver cannot stall results.

module batched_d_choice_load_balancer_core
  import bdlb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  ball_t                    ball_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                     res_valid_o,
  output result_t                  res_o
);

  typedef enum logic [20:0] {
    ST_CLEAR  = 21'h000001,
    ST_IDLE   = 21'h000002,
    ST_LD_A   = 21'h000004,
    ST_LD_B   = 21'h000008,
    ST_LD_CMP = 21'h000010,
    ST_BUF_RD = 21'h000020,
    ST_BUF_WR = 21'h000040,
    ST_COUNT  = 21'h000080,
    ST_MRG_RD = 21'h000100,
    ST_MRG_WR = 21'h000200,
    ST_HP_RD  = 21'h000400,
    ST_HP_CAP = 21'h000800,
    ST_SF_C1  = 21'h001000,
    ST_SF_C2  = 21'h002000,
    ST_SF_C3  = 21'h004000,
    ST_SF_CMP = 21'h008000,
    ST_EX_RD0 = 21'h010000,
    ST_EX_RD1 = 21'h020000,
    ST_EX_CAP = 21'h040000,
    ST_DIV    = 21'h080000,
    ST_REPORT = 21'h100000
  } state_e;

  localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;
  localparam logic [TOT_BITS-1:0]  TOT_MAX  = '1;
  localparam logic [AW-1:0]        LAST_BIN = AW'(MAX_BINS - 1);

  // configuration registers
  logic [10:0] bins_q, quant_q;
  logic [19:0] bsize_q;
  logic [2:0]  mode_q;
  logic [1:0]  dcount_q;

  // control and datapath registers
  state_e state_q, state_d;
  ball_t  ball_q, ball_d;
  logic [AW-1:0] pick_q, pick_d;
  logic [LOAD_BITS-1:0] la_q, la_d;
  logic bad_q, bad_d;
  logic [TOT_BITS-1:0] total_q, total_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [LOAD_BITS-1:0] max_q, max_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [AW-1:0] r_q, r_d;
  logic [CW-1:0] e_q, e_d;
  logic [AW-1:0] ci_q, ci_d;
  logic [LOAD_BITS-1:0] cv_q, cv_d, rv_q, rv_d, t_q, t_d;
  logic heap_q, heap_d;
  logic [TOT_BITS-1:0] quo_q, quo_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [DCNT_BITS-1:0] dcnt_q, dcnt_d;
  logic done_q, done_d;
  logic res_valid_q, res_valid_d;
  result_t res_q, res_d;

  // memory ports
  logic ld_we, bf_we;
  logic [AW-1:0] ld_waddr, ld_raddr, bf_waddr, bf_raddr;
  logic [LOAD_BITS-1:0] ld_wdata, ld_rdata, bf_wdata, bf_rdata;

  bdlb_ram #(.WIDTH(LOAD_BITS), .DEPTH(MAX_BINS)) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (ld_wdata),
    .raddr_i (ld_raddr),
    .rdata_o (ld_rdata)
  );

  bdlb_ram #(.WIDTH(LOAD_BITS), .DEPTH(MAX_BINS)) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (bf_we),
    .waddr_i (bf_waddr),
    .wdata_i (bf_wdata),
    .raddr_i (bf_raddr),
    .rdata_o (bf_rdata)
  );

  // effective bin count: zero acts as one, above MAX_BINS clamps
  logic [CW-1:0] n_eff;
  always_comb begin
    if (bins_q == 11'd0) begin
      n_eff = CW'(1);
    end else if (32'(bins_q) > MAX_BINS) begin
      n_eff = CW'(MAX_BINS);
    end else begin
      n_eff = CW'(bins_q);
    end
  end

  // selection on the incoming item (index rules and range checks)
  logic [CW-1:0] sa, sb, sc;
  logic in_bad, in_need_load;
  logic [AW-1:0] in_pick;
  logic [1:0] d_eff;
  always_comb begin
    sa = CW'(ball_i.sample_a);
    sb = CW'(ball_i.sample_b);
    sc = CW'(ball_i.sample_c);
    d_eff = (dcount_q == 2'd0) ? 2'd1 : dcount_q;
    in_bad = 1'b0;
    in_need_load = 1'b0;
    in_pick = AW'(ball_i.sample_a);
    if (sa >= n_eff) begin
      in_bad = 1'b1;
    end else begin
      case (mode_q)
        MODE_D_INDEX: begin
          if (d_eff >= 2'd2) begin
            if (sb >= n_eff) in_bad = 1'b1;
            else if (sb > CW'(in_pick)) in_pick = AW'(ball_i.sample_b);
          end
          if (d_eff == 2'd3) begin
            if (sc >= n_eff) in_bad = 1'b1;
            else if (sc > CW'(in_pick)) in_pick = AW'(ball_i.sample_c);
          end
        end
        MODE_BETA_INDEX: begin
          if (ball_i.coin) begin
            if (sb >= n_eff) in_bad = 1'b1;
            else if (sb > sa) in_pick = AW'(ball_i.sample_b);
          end
        end
        MODE_BETA_LOAD: begin
          if (ball_i.coin) begin
            if (sb >= n_eff) in_bad = 1'b1;
            else in_need_load = 1'b1;
          end
        end
        MODE_QUANTILE: begin
          if (sa < quant_q) begin
            if (sb >= n_eff) in_bad = 1'b1;
            else in_pick = AW'(ball_i.sample_b);
          end
        end
        default: begin
          if (sb >= n_eff) in_bad = 1'b1;
          else in_need_load = 1'b1;
        end
      endcase
    end
  end

  // helpers
  logic [LOAD_BITS:0] buf_sum, mrg_sum;
  logic [TOT_BITS:0] tot_sum;
  logic [LOAD_BITS-1:0] buf_new, mrg_new;
  logic [CW-1:0] c_idx;
  logic [CNT_BITS-1:0] cnt_inc;
  logic [CNT_BITS-1:0] bs_eff;
  logic [CW:0] rem_t;
  logic [TOT_BITS-1:0] max_ext;

  assign buf_sum = {1'b0, bf_rdata} + (LOAD_BITS+1)'(ball_q.weight);
  assign buf_new = buf_sum[LOAD_BITS] ? LOAD_MAX : buf_sum[LOAD_BITS-1:0];
  assign mrg_sum = {1'b0, ld_rdata} + {1'b0, bf_rdata};
  assign mrg_new = mrg_sum[LOAD_BITS] ? LOAD_MAX : mrg_sum[LOAD_BITS-1:0];
  assign tot_sum = {1'b0, total_q} + (TOT_BITS+1)'(ball_q.weight);
  assign c_idx   = {r_q, 1'b1};
  assign cnt_inc = cnt_q + CNT_BITS'(1);
  assign bs_eff  = (bsize_q == 20'd0) ? CNT_BITS'(1) : CNT_BITS'(bsize_q);
  assign rem_t   = {rem_q, quo_q[TOT_BITS-1]};
  assign max_ext = TOT_BITS'(max_q);

  always_comb begin
    state_d = state_q;
    ball_d = ball_q;
    pick_d = pick_q;
    la_d = la_q;
    bad_d = bad_q;
    total_d = total_q;
    cnt_d = cnt_q;
    max_d = max_q;
    idx_d = idx_q;
    hi_d = hi_q;
    r_d = r_q;
    e_d = e_q;
    ci_d = ci_q;
    cv_d = cv_q;
    rv_d = rv_q;
    t_d = t_q;
    heap_d = heap_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dcnt_d = dcnt_q;
    done_d = done_q;
    res_valid_d = 1'b0;
    res_d = res_q;

    ld_we = 1'b0;
    ld_waddr = r_q;
    ld_wdata = rv_q;
    ld_raddr = idx_q;
    bf_we = 1'b0;
    bf_waddr = idx_q;
    bf_wdata = '0;
    bf_raddr = pick_q;

    case (state_q)
      ST_CLEAR: begin
        // zero one entry of both memories per cycle
        ld_we = 1'b1;
        ld_waddr = idx_q;
        ld_wdata = '0;
        bf_we = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_q == LAST_BIN) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          ball_d = ball_i;
          bad_d = in_bad;
          pick_d = in_bad ? '0 : in_pick;
          if (in_bad) state_d = ST_COUNT;
          else if (in_need_load) state_d = ST_LD_A;
          else state_d = ST_BUF_RD;
        end
      end
      ST_LD_A: begin
        ld_raddr = AW'(ball_q.sample_a);
        state_d = ST_LD_B;
      end
      ST_LD_B: begin
        ld_raddr = AW'(ball_q.sample_b);
        la_d = ld_rdata;
        state_d = ST_LD_CMP;
      end
      ST_LD_CMP: begin
        // ties go to the first sample
        pick_d = (la_q <= ld_rdata) ? AW'(ball_q.sample_a) : AW'(ball_q.sample_b);
        state_d = ST_BUF_RD;
      end
      ST_BUF_RD: begin
        bf_raddr = pick_q;
        state_d = ST_BUF_WR;
      end
      ST_BUF_WR: begin
        bf_we = 1'b1;
        bf_waddr = pick_q;
        bf_wdata = buf_new;
        total_d = tot_sum[TOT_BITS] ? TOT_MAX : tot_sum[TOT_BITS-1:0];
        state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (cnt_inc >= bs_eff || cnt_inc == '0) begin
          cnt_d = '0;
          done_d = 1'b1;
          idx_d = '0;
          state_d = ST_MRG_RD;
        end else begin
          cnt_d = cnt_inc;
          done_d = 1'b0;
          state_d = ST_REPORT;
        end
      end
      ST_MRG_RD: begin
        ld_raddr = idx_q;
        bf_raddr = idx_q;
        state_d = ST_MRG_WR;
      end
      ST_MRG_WR: begin
        // fold the buffer into the load, clear the buffer, track the maximum
        ld_we = 1'b1;
        ld_waddr = idx_q;
        ld_wdata = mrg_new;
        bf_we = 1'b1;
        bf_waddr = idx_q;
        bf_wdata = '0;
        if (mrg_new > max_q) max_d = mrg_new;
        idx_d = idx_q + AW'(1);
        if (idx_q == LAST_BIN) begin
          if (n_eff >= CW'(2)) begin
            heap_d = 1'b1;
            hi_d = AW'((n_eff >> 1) - CW'(1));
            state_d = ST_HP_RD;
          end else begin
            quo_d = total_q;
            rem_d = '0;
            dcnt_d = '0;
            state_d = ST_DIV;
          end
        end else begin
          state_d = ST_MRG_RD;
        end
      end
      ST_HP_RD: begin
        ld_raddr = hi_q;
        state_d = ST_HP_CAP;
      end
      ST_HP_CAP: begin
        rv_d = ld_rdata;
        r_d = hi_q;
        e_d = n_eff;
        state_d = ST_SF_C1;
      end
      ST_SF_C1: begin
        if (c_idx >= e_q) begin
          // leaf reached: drop the sifted value into the hole
          ld_we = 1'b1;
          ld_waddr = r_q;
          ld_wdata = rv_q;
          state_d = ST_EX_RD0;
          if (heap_q) begin
            if (hi_q == '0) begin
              heap_d = 1'b0;
              e_d = n_eff;
            end else begin
              hi_d = hi_q - AW'(1);
              state_d = ST_HP_RD;
            end
          end else if (e_q <= CW'(1)) begin
            quo_d = total_q;
            rem_d = '0;
            dcnt_d = '0;
            state_d = ST_DIV;
          end
        end else begin
          ld_raddr = c_idx[AW-1:0];
          state_d = ST_SF_C2;
        end
      end
      ST_SF_C2: begin
        cv_d = ld_rdata;
        ci_d = c_idx[AW-1:0];
        if (c_idx + CW'(1) < e_q) begin
          ld_raddr = AW'(c_idx + CW'(1));
          state_d = ST_SF_C3;
        end else begin
          state_d = ST_SF_CMP;
        end
      end
      ST_SF_C3: begin
        if (ld_rdata < cv_q) begin
          cv_d = ld_rdata;
          ci_d = ci_q + AW'(1);
        end
        state_d = ST_SF_CMP;
      end
      ST_SF_CMP: begin
        ld_we = 1'b1;
        ld_waddr = r_q;
        if (cv_q < rv_q) begin
          // move the smaller child up and descend
          ld_wdata = cv_q;
          r_d = ci_q;
          state_d = ST_SF_C1;
        end else begin
          ld_wdata = rv_q;
          state_d = ST_EX_RD0;
          if (heap_q) begin
            if (hi_q == '0) begin
              heap_d = 1'b0;
              e_d = n_eff;
            end else begin
              hi_d = hi_q - AW'(1);
              state_d = ST_HP_RD;
            end
          end else if (e_q <= CW'(1)) begin
            quo_d = total_q;
            rem_d = '0;
            dcnt_d = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_EX_RD0: begin
        ld_raddr = '0;
        state_d = ST_EX_RD1;
      end
      ST_EX_RD1: begin
        t_d = ld_rdata;
        ld_raddr = AW'(e_q - CW'(1));
        state_d = ST_EX_CAP;
      end
      ST_EX_CAP: begin
        // swap root to the end, then sift the old last value from the root
        rv_d = ld_rdata;
        ld_we = 1'b1;
        ld_waddr = AW'(e_q - CW'(1));
        ld_wdata = t_q;
        r_d = '0;
        e_d = e_q - CW'(1);
        state_d = ST_SF_C1;
      end
      ST_DIV: begin
        // one quotient bit per cycle
        if (rem_t >= {1'b0, n_eff}) begin
          rem_d = CW'(rem_t - {1'b0, n_eff});
          quo_d = {quo_q[TOT_BITS-2:0], 1'b1};
        end else begin
          rem_d = rem_t[CW-1:0];
          quo_d = {quo_q[TOT_BITS-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCNT_BITS'(1);
        if (dcnt_q == DCNT_BITS'(TOT_BITS - 1)) state_d = ST_REPORT;
      end
      ST_REPORT: begin
        res_valid_d = 1'b1;
        res_d.chosen_bin = 10'(pick_q);
        res_d.batch_done = done_q;
        res_d.max_load_out = 40'(max_q);
        res_d.status = bad_q;
        if (done_q && max_ext > quo_q) res_d.gap_out = 40'(max_ext - quo_q);
        else res_d.gap_out = '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q <= '0;
      total_q <= '0;
      cnt_q <= '0;
      max_q <= '0;
      heap_q <= 1'b0;
      done_q <= 1'b0;
      res_valid_q <= 1'b0;
      bins_q <= 11'd1024;
      bsize_q <= 20'd1024;
      mode_q <= MODE_TWO_LOAD;
      dcount_q <= 2'd2;
      quant_q <= 11'd0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      total_q <= total_d;
      cnt_q <= cnt_d;
      max_q <= max_d;
      heap_q <= heap_d;
      done_q <= done_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BINS_IN_USE:   bins_q <= cfg_data_i[10:0];
          REG_BATCH_SIZE:    bsize_q <= cfg_data_i;
          REG_SELECTOR_MODE: mode_q <= cfg_data_i[2:0];
          REG_CHOICE_COUNT:  dcount_q <= cfg_data_i[1:0];
          REG_QUANTILE_CUT:  quant_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    ball_q <= ball_d;
    pick_q <= pick_d;
    la_q <= la_d;
    bad_q <= bad_d;
    hi_q <= hi_d;
    r_q <= r_d;
    e_q <= e_d;
    ci_q <= ci_d;
    cv_q <= cv_d;
    rv_q <= rv_d;
    t_q <= t_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dcnt_q <= dcnt_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

endmodule

[hdl/bdlb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bdlb_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the batched d-choice load balancer core. Balls are
// queued by a stimulus process and driven by a clocked driver. A clocked
// monitor compares every result strobe against a bin-placement predictor
// that tracks loads, batch buffers, running max and batch count. Register
// settings change only while the core is idle.
// ----------------------------------------------------------------------------
module tb;
  import bdlb_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam longint unsigned LOAD_MAX  = (64'd1 << LOAD_BITS) - 1;
  localparam longint unsigned TOTAL_MAX = (64'd1 << TOT_BITS) - 1;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  ball_t                    ball;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     res_valid;
  result_t                  res;

  batched_d_choice_load_balancer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .ball_i      (ball),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Shadow copy of the core's state and registers.
  longint unsigned bin_load[MAX_BINS];
  longint unsigned bin_buf[MAX_BINS];
  longint unsigned run_max;
  longint unsigned total_w;
  logic [19:0]     balls_seen;
  logic [10:0]     reg_bins;
  logic [19:0]     reg_batch;
  logic [2:0]      reg_mode;
  logic [1:0]      reg_d;
  logic [10:0]     reg_qcut;

  ball_t   ball_q[$];       // balls waiting to be driven
  result_t placement_q[$];  // predicted results, oldest first
  int      fail_count;
  int      idle_pct;        // sender idle chance per cycle, in percent
  int      wd_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned sat_add(longint unsigned x, longint unsigned y,
                                              longint unsigned lim);
    longint unsigned s;
    s = x + y;
    return (s > lim) ? lim : s;
  endfunction

  // Place one ball, merge and sort at batch end, and return the expected result.
  function automatic result_t place_ball(ball_t b);
    result_t         r;
    int              n;
    int unsigned     a, bb, c, pick;
    bit              bad;
    logic [19:0]     bs;
    longint unsigned avg;
    longint unsigned srt[];
    n  = (reg_bins == 0) ? 1 : ((reg_bins > MAX_BINS) ? MAX_BINS : int'(reg_bins));
    bs = (reg_batch == 0) ? 20'd1 : reg_batch;
    a = 32'(b.sample_a); bb = 32'(b.sample_b); c = 32'(b.sample_c);
    bad = 1'b0;
    pick = a;
    r = '0;
    if (a >= n) begin
      bad = 1'b1;
    end else begin
      case (reg_mode)
        MODE_D_INDEX: begin
          if (reg_d >= 2) begin
            if (bb >= n) bad = 1'b1; else if (bb > pick) pick = bb;
          end
          if (reg_d >= 3) begin
            if (c >= n) bad = 1'b1; else if (c > pick) pick = c;
          end
        end
        MODE_BETA_INDEX: begin
          if (b.coin) begin
            if (bb >= n) bad = 1'b1; else if (bb > a) pick = bb;
          end
        end
        MODE_BETA_LOAD: begin
          if (b.coin) begin
            if (bb >= n) bad = 1'b1;
            else pick = (bin_load[a] <= bin_load[bb]) ? a : bb;
          end
        end
        MODE_QUANTILE: begin
          if (a < reg_qcut) begin
            if (bb >= n) bad = 1'b1; else pick = bb;
          end
        end
        default: begin
          // two-choice by load; unused codes land here too
          if (bb >= n) bad = 1'b1;
          else pick = (bin_load[a] <= bin_load[bb]) ? a : bb;
        end
      endcase
    end
    if (bad) begin
      pick = 0;
    end else begin
      bin_buf[pick] = sat_add(bin_buf[pick], 64'(b.weight), LOAD_MAX);
      total_w = sat_add(total_w, 64'(b.weight), TOTAL_MAX);
    end
    balls_seen = balls_seen + 20'd1;
    if (balls_seen >= bs || balls_seen == 0) begin
      r.batch_done = 1'b1;
      balls_seen = '0;
      for (int i = 0; i < MAX_BINS; i++) begin
        bin_load[i] = sat_add(bin_load[i], bin_buf[i], LOAD_MAX);
        bin_buf[i]  = 0;
        if (bin_load[i] > run_max) run_max = bin_load[i];
      end
      srt = new[n];
      for (int i = 0; i < n; i++) srt[i] = bin_load[i];
      srt.rsort();
      for (int i = 0; i < n; i++) bin_load[i] = srt[i];
      avg = total_w / n;
      r.gap_out = (run_max > avg) ? 40'(run_max - avg) : 40'd0;
    end
    r.chosen_bin   = pick[9:0];
    r.max_load_out = 40'(run_max);
    r.status       = bad;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Driver: take the current ball on acceptance, then pick the next one.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
      ball  <= '0;
    end else begin
      logic  nxt_start;
      ball_t nxt_ball;
      nxt_start = start;
      nxt_ball  = ball;
      if (start && !busy) begin
        placement_q.push_back(place_ball(ball));
        nxt_start = 1'b0;
      end
      if (!nxt_start && ball_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt_ball  = ball_q.pop_front();
        nxt_start = 1'b1;
      end
      start <= nxt_start;
      ball  <= nxt_ball;
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && res_valid) begin
      if (placement_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        result_t want;
        want = placement_q.pop_front();
        if (res.chosen_bin !== want.chosen_bin)
          report_mismatch("chosen_bin", res.chosen_bin, want.chosen_bin);
        if (res.batch_done !== want.batch_done)
          report_mismatch("batch_done", res.batch_done, want.batch_done);
        if (res.max_load_out !== want.max_load_out)
          report_mismatch("max_load_out", res.max_load_out, want.max_load_out);
        if (res.gap_out !== want.gap_out)
          report_mismatch("gap_out", res.gap_out, want.gap_out);
        if (res.status !== want.status)
          report_mismatch("status", res.status, want.status);
      end
    end
  end

  // Watchdog: count cycles in which no item moves either way.
  always @(posedge clk) begin
    if ((start && !busy) || res_valid) begin
      wd_count <= 0;
    end else if (wd_count >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  // Hold until every queued ball is taken, every result is in and busy drops.
  task automatic wait_idle();
    do @(posedge clk);
    while (ball_q.size() != 0 || start || placement_q.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_BINS_IN_USE:   reg_bins  = val[10:0];
      REG_BATCH_SIZE:    reg_batch = val[19:0];
      REG_SELECTOR_MODE: reg_mode  = val[2:0];
      REG_CHOICE_COUNT:  reg_d     = val[1:0];
      REG_QUANTILE_CUT:  reg_qcut  = val[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int n, int bs, logic [2:0] mode, int d, int qcut);
    wait_idle();
    write_reg(REG_BINS_IN_USE, CFG_DATA_BITS'(n));
    write_reg(REG_BATCH_SIZE, CFG_DATA_BITS'(bs));
    write_reg(REG_SELECTOR_MODE, CFG_DATA_BITS'(mode));
    write_reg(REG_CHOICE_COUNT, CFG_DATA_BITS'(d));
    write_reg(REG_QUANTILE_CUT, CFG_DATA_BITS'(qcut));
  endtask

  task automatic add_ball(int a, int b, int c, bit coin, int w);
    ball_t x;
    x.sample_a = 10'(a); x.sample_b = 10'(b); x.sample_c = 10'(c);
    x.coin = coin; x.weight = 16'(w);
    ball_q.push_back(x);
  endtask

  // Mostly in-range samples with random content; a few land anywhere.
  function automatic int pick_sample(int n);
    return ($urandom_range(0, 99) < 88) ? $urandom_range(0, n - 1) : $urandom_range(0, 1023);
  endfunction

  task automatic add_random(int n, int count);
    int w;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = 65535;
        default: w = $urandom_range(0, 65535);
      endcase
      add_ball(pick_sample(n), pick_sample(n), pick_sample(n), $urandom_range(0, 1), w);
    end
  endtask

  initial begin
    int n, bs, nb;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    fail_count = 0;
    wd_count   = 0;
    idle_pct   = 28;
    for (int i = 0; i < MAX_BINS; i++) begin
      bin_load[i] = 0;
      bin_buf[i]  = 0;
    end
    run_max = 0; total_w = 0; balls_seen = '0;
    reg_bins = 11'd1024; reg_batch = 20'd1024; reg_mode = MODE_TWO_LOAD;
    reg_d = 2'd2; reg_qcut = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every rule, out-of-range samples on used and unused inputs.
    setup(4, 3, MODE_D_INDEX, 3, 0);
    add_ball(0, 1, 2, 0, 256);
    add_ball(3, 3, 3, 1, 65535);
    add_ball(1, 2, 7, 0, 100);     // third sample out of range
    add_ball(9, 0, 0, 1, 5);       // first sample out of range
    add_ball(2, 1, 0, 1, 0);
    setup(4, 0, MODE_TWO_LOAD, 0, 0);
    add_ball(0, 1, 0, 0, 300);
    add_ball(1, 0, 0, 0, 300);     // first sample is the lighter bin
    add_ball(3, 9, 0, 0, 1);
    setup(4, 2, MODE_BETA_INDEX, 1, 0);
    add_ball(1, 3, 0, 1, 700);
    add_ball(2, 3, 0, 0, 700);
    add_ball(1, 800, 0, 1, 7);
    setup(4, 2, MODE_BETA_LOAD, 2, 0);
    add_ball(0, 3, 0, 1, 1000);
    add_ball(2, 1023, 0, 0, 1000); // second sample unused, so not checked
    setup(4, 3, MODE_QUANTILE, 2, 2);
    add_ball(0, 3, 0, 0, 65535);
    add_ball(3, 1000, 0, 1, 65535);
    add_ball(1, 4, 0, 0, 12);
    setup(0, 1048575, 3'd7, 3, 1024);  // zero bins acts as one
    add_ball(0, 0, 0, 1, 40000);
    add_ball(0, 1, 0, 0, 40000);
    setup(2000, 2, MODE_D_INDEX, 1, 0); // oversized count clamps to MAX_BINS
    add_ball(1023, 682, 341, 1, 21845);
    add_ball(512, 0, 1023, 0, 43690);

    // Random phases: mostly small bin counts and short batches, with two full-size phases.
    for (int p = 0; p < 13; p++) begin
      if (p == 4) idle_pct = 88;
      if (p == 8) idle_pct = 0;
      if (p == 6 || p == 11) begin
        n = 1024; bs = $urandom_range(40, 80); nb = bs + $urandom_range(5, 20);
      end else begin
        case ($urandom_range(0, 5))
          0:       n = 1;
          1:       n = 2;
          default: n = $urandom_range(3, 64);
        endcase
        bs = $urandom_range(1, 16);
        nb = 150;
      end
      setup(n, bs, 3'($urandom_range(0, 7)), $urandom_range(0, 3), $urandom_range(0, n + 1));
      add_random(n, nb);
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[batched_d_choice_load_balancer_core.f]
hdl/bdlb_pkg.sv
hdl/bdlb_ram.sv
hdl/batched_d_choice_load_balancer_core.sv
tb/tb.sv
